// File: rtl/smr_pkg.sv
// Shared types, register codes and fixed-point helpers for the spring mesh block.
// No dependencies; used by every module of the block but smr_isqrt.
package smr_pkg;

    localparam int GRID_DEFAULT = 7;

    localparam logic [1:0] REG_REST_H = 2'd0;
    localparam logic [1:0] REG_REST_V = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_PLACE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic        [5:0]  node_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               zero_velocity;
    } req_t;

    typedef struct packed {
        logic [11:0] rest_h;
        logic [11:0] rest_v;
        logic [23:0] gain;
    } cfg_t;

    typedef struct packed {
        logic        [5:0]  node_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               last;
    } res_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return sat32(s);
    endfunction

    // Difference clamped to the symmetric range +/-(2^31-1).
    function automatic logic signed [31:0] diff_clamp(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [32:0] d;
        logic signed [31:0] r;
        d = 33'(a) - 33'(b);
        if (d > 33'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (d < -33'sd2147483647)
            r = 32'sh80000001;
        else
            r = d[31:0];
        return r;
    endfunction

    // Arithmetic shift right with rounding half away from zero.
    function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                     input int s);
        logic [63:0] m;
        logic [63:0] half;
        logic [63:0] q;
        half = 64'd1 << (s - 1);
        m    = v[63] ? 64'(-v) : 64'(v);
        q    = (m + half) >> s;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// File: rtl/smr_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on nothing but the clock and reset.
module smr_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [62:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] rad_reg;
    logic [35:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] rem_shift;
    logic [35:0] trial;

    assign rem_shift = {rem_reg[33:0], rad_reg[63:62]};
    assign trial     = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {1'b0, radicand};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/smr_core.sv
// Node memories, sweep sequencer and spring arithmetic of the mesh.
// Depends on smr_pkg and smr_isqrt.
module smr_core
    import smr_pkg::*;
#(
    parameter int GRID = GRID_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    input  cfg_t cfg,
    output logic idle,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int NODES  = GRID * GRID;
    localparam int AW     = $clog2(NODES);
    localparam int CW     = $clog2(GRID);
    localparam int FIRST  = GRID + 1;
    localparam int LAST_N = (GRID - 2) * GRID + GRID - 2;

    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_RDS  = 15'h0002,
        S_ADDV = 15'h0004,
        S_RDN  = 15'h0008,
        S_DIFF = 15'h0010,
        S_SQX  = 15'h0020,
        S_SQY  = 15'h0040,
        S_SQGO = 15'h0080,
        S_SQWT = 15'h0100,
        S_FRC1 = 15'h0200,
        S_FRC2 = 15'h0400,
        S_MULX = 15'h0800,
        S_MULY = 15'h1000,
        S_ACCY = 15'h2000,
        S_UPD  = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] pos_mem [NODES];
    logic [63:0] vel_mem [NODES];
    logic [NODES-1:0] pos_vld_reg;
    logic [NODES-1:0] vel_vld_reg;
    logic [63:0] pos_rd_reg;
    logic [63:0] vel_rd_reg;
    logic        pos_rv_reg;
    logic        vel_rv_reg;

    logic          pos_we, vel_we;
    logic [AW-1:0] pos_wa, pos_ra, nb_addr;
    logic [63:0]   pos_wd, vel_wd;

    logic [AW-1:0] n_reg;
    logic [CW-1:0] c_reg;
    logic [1:0]    k_reg;

    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic signed [31:0] dx_reg, dy_reg, force_reg;
    logic signed [63:0] prod_reg, accx_reg, accy_reg;
    logic [62:0]        sq_reg;

    logic signed [31:0] qx, qy, vqx, vqy, ax, ay, sx, sy;
    logic signed [31:0] nvx, nvy, npx, npy;
    logic signed [33:0] stretch;
    logic [11:0]        rest;
    logic               place_ok;
    logic               sq_done;
    logic [31:0]        root;

    smr_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SQGO),
        .radicand (sq_reg),
        .done     (sq_done),
        .root     (root)
    );

    assign qx  = pos_rv_reg ? pos_rd_reg[31:0]  : 32'sd0;
    assign qy  = pos_rv_reg ? pos_rd_reg[63:32] : 32'sd0;
    assign vqx = vel_rv_reg ? vel_rd_reg[31:0]  : 32'sd0;
    assign vqy = vel_rv_reg ? vel_rd_reg[63:32] : 32'sd0;
    assign ax  = dx_reg[31] ? -dx_reg : dx_reg;
    assign ay  = dy_reg[31] ? -dy_reg : dy_reg;
    assign rest    = k_reg[1] ? cfg.rest_v : cfg.rest_h;
    assign stretch = $signed({2'b00, root}) - $signed({6'd0, rest, 16'd0});
    assign sx  = sat32(accx_reg);
    assign sy  = sat32(accy_reg);
    assign nvx = add_sat(vx_reg, sx);
    assign nvy = add_sat(vy_reg, sy);
    assign npx = add_sat(px_reg, sx);
    assign npy = add_sat(py_reg, sy);
    assign place_ok = ({1'b0, req.node_index} < 7'(NODES));

    always_comb
    begin
        case (k_reg)
            2'd0:    nb_addr = n_reg - AW'(1);
            2'd1:    nb_addr = n_reg + AW'(1);
            2'd2:    nb_addr = n_reg - AW'(GRID);
            default: nb_addr = n_reg + AW'(GRID);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pos_we     = 1'b0;
        vel_we     = 1'b0;
        pos_wa     = n_reg;
        pos_wd     = {npy, npx};
        vel_wd     = {nvy, nvx};
        pos_ra     = (state_reg == S_RDN) ? nb_addr : n_reg;
        res_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.kind == KIND_PLACE)
                    begin
                        pos_we = place_ok;
                        vel_we = place_ok && req.zero_velocity;
                        pos_wa = req.node_index[AW-1:0];
                        pos_wd = {req.pos_y, req.pos_x};
                        vel_wd = '0;
                    end
                    else
                    begin
                        state_next = S_RDS;
                    end
                end
            end
            S_RDS:  state_next = S_ADDV;
            S_ADDV: state_next = S_RDN;
            S_RDN:  state_next = S_DIFF;
            S_DIFF: state_next = S_SQX;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_SQGO;
            S_SQGO: state_next = S_SQWT;
            S_SQWT:
            begin
                if (sq_done)
                    state_next = S_FRC1;
            end
            S_FRC1: state_next = S_FRC2;
            S_FRC2: state_next = S_MULX;
            S_MULX: state_next = S_MULY;
            S_MULY: state_next = S_ACCY;
            S_ACCY: state_next = (k_reg == 2'd3) ? S_UPD : S_RDN;
            S_UPD:
            begin
                if (res_ready)
                begin
                    pos_we    = 1'b1;
                    vel_we    = 1'b1;
                    res_valid = 1'b1;
                    state_next = (n_reg == AW'(LAST_N)) ? S_IDLE : S_RDS;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pos_vld_reg <= '0;
            vel_vld_reg <= '0;
            pos_rv_reg  <= 1'b0;
            vel_rv_reg  <= 1'b0;
            n_reg       <= AW'(FIRST);
            c_reg       <= CW'(1);
            k_reg       <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_rv_reg <= pos_vld_reg[pos_ra];
            vel_rv_reg <= vel_vld_reg[n_reg];
            if (pos_we)
                pos_vld_reg[pos_wa] <= 1'b1;
            if (vel_we)
                vel_vld_reg[pos_wa] <= 1'b1;
            if (state_reg == S_IDLE)
            begin
                n_reg <= AW'(FIRST);
                c_reg <= CW'(1);
            end
            if (state_reg == S_ADDV)
                k_reg <= '0;
            if (state_reg == S_ACCY)
                k_reg <= k_reg + 2'd1;
            if (state_reg == S_UPD && res_ready)
            begin
                if (c_reg == CW'(GRID - 2))
                begin
                    c_reg <= CW'(1);
                    n_reg <= n_reg + AW'(3);
                end
                else
                begin
                    c_reg <= c_reg + CW'(1);
                    n_reg <= n_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_wa] <= pos_wd;
        pos_rd_reg <= pos_mem[pos_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vel_we)
            vel_mem[pos_wa] <= vel_wd;
        vel_rd_reg <= vel_mem[n_reg];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_ADDV:
            begin
                px_reg   <= add_sat(qx, vqx);
                py_reg   <= add_sat(qy, vqy);
                vx_reg   <= vqx;
                vy_reg   <= vqy;
                accx_reg <= '0;
                accy_reg <= '0;
            end
            S_DIFF:
            begin
                dx_reg <= diff_clamp(px_reg, qx);
                dy_reg <= diff_clamp(py_reg, qy);
            end
            S_SQX:  sq_reg <= 63'(ax[30:0] * ax[30:0]);
            S_SQY:  sq_reg <= sq_reg + 63'(ay[30:0] * ay[30:0]);
            S_FRC1: prod_reg <= 64'(stretch * $signed({1'b0, cfg.gain}));
            S_FRC2: force_reg <= sat32(-shr_round(prod_reg, 16));
            S_MULX: prod_reg <= 64'(dx_reg * force_reg);
            S_MULY:
            begin
                accx_reg <= accx_reg + shr_round(prod_reg, 24);
                prod_reg <= 64'(dy_reg * force_reg);
            end
            S_ACCY: accy_reg <= accy_reg + shr_round(prod_reg, 24);
            default:
            begin
            end
        endcase
    end

    assign idle           = (state_reg == S_IDLE);
    assign res.node_index = 6'(n_reg);
    assign res.pos_x      = npx;
    assign res.pos_y      = npy;
    assign res.last       = (n_reg == AW'(LAST_N));

endmodule

// File: rtl/spring_mesh_relaxation_step.sv
// Top level of the spring mesh block: stream ports, register file, result register.
// Depends on smr_pkg and smr_core.
//
//  port group   dir  width  contents
//  s_*          in   72+1   request: place one node or run one sweep
//  m_*          out  72+1   one updated interior node per result
//  cfg_*        in   2+24   register writes
//
// A place request for a node in range is written to the node memories as it is
// accepted. A tick runs through the interior nodes in turn: node read, velocity
// add, four spring terms that each wait on the 32-step square root, and write-back;
// (GRID-2)^2 results per tick. Reset clears all positions and velocities at once
// through per-entry valid bits. A stalled result holds the sweep in place.
module spring_mesh_relaxation_step
    import smr_pkg::*;
#(
    parameter int GRID = GRID_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // node_index, pos_x, pos_y, zero_velocity
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // node_index_res, pos_x_res, pos_y_res
    output logic        m_tlast,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    cfg_t cfg_reg;
    req_t req;
    res_t res, res_reg;
    logic m_valid_reg;
    logic core_idle, res_valid, res_ready;

    assign req.kind          = s_tuser;
    assign req.node_index    = s_tdata[5:0];
    assign req.pos_x         = s_tdata[37:6];
    assign req.pos_y         = s_tdata[69:38];
    assign req.zero_velocity = s_tdata[70];

    assign s_tready  = core_idle;
    assign res_ready = !m_valid_reg || m_tready;

    smr_core #(
        .GRID (GRID)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && s_tready),
        .req       (req),
        .cfg       (cfg_reg),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rest_h <= 12'd182;
            cfg_reg.rest_v <= 12'd102;
            cfg_reg.gain   <= 24'd1678;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_REST_H: cfg_reg.rest_h <= cfg_data[11:0];
                    REG_REST_V: cfg_reg.rest_v <= cfg_data[11:0];
                    REG_GAIN:   cfg_reg.gain   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (res_valid)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            res_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, res_reg.pos_y, res_reg.pos_x, res_reg.node_index};
    assign m_tlast  = res_reg.last;

endmodule

// File: rtl/smr_checker.sv
// Port-level checks for the spring mesh block, bound to the top level.
// Depends on smr_pkg.
module smr_checker
    import smr_pkg::*;
#(
    parameter int GRID = GRID_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);

    localparam int LAST_N = (GRID - 2) * GRID + GRID - 2;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == KIND_TICK |=> !s_tready)
        else $error("tick request did not start a sweep");

    a_last_node: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[5:0] == 6'(LAST_N))
        else $error("last flag on wrong node");

    a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result without a sweep");

endmodule

bind spring_mesh_relaxation_step smr_checker #(
    .GRID (GRID)
) u_smr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
